// ----- rtl/byte_ring_fifo_with_search_defines.svh -----
// assertion macros for the byte ring fifo with search
// used by the top level only; no other dependencies
`ifndef BYTE_RING_FIFO_WITH_SEARCH_DEFINES_SVH
`define BYTE_RING_FIFO_WITH_SEARCH_DEFINES_SVH
`ifndef SYNTHESIS
`define BRFS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define BRFS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BRFS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define BRFS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- rtl/brfs_pkg.sv -----
// shared constants, types and helpers for the byte ring fifo with search
// no dependencies
package brfs_pkg;
  localparam int CAPACITY   = 63;
  localparam int SLOT_COUNT = CAPACITY + 1;
  localparam int PTR_W      = $clog2(SLOT_COUNT);
  localparam int CNT_W      = 6;
  localparam int OP_W       = 3;
  localparam int BYTE_W     = 8;

  localparam logic [OP_W-1:0] OP_PUSH  = 3'd0;
  localparam logic [OP_W-1:0] OP_POP   = 3'd1;
  localparam logic [OP_W-1:0] OP_FLUSH = 3'd2;
  localparam logic [OP_W-1:0] OP_FIND  = 3'd3;
  localparam logic [OP_W-1:0] OP_COPY  = 3'd4;
  localparam logic [OP_W-1:0] OP_NOP   = 3'd7;

  typedef logic [PTR_W-1:0] ptr_t;

  // one classified command in the queue between front and back
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [BYTE_W-1:0] arg;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_q_t;

  function automatic ptr_t ptr_inc(input ptr_t p);
    ptr_inc = (p == PTR_W'(SLOT_COUNT - 1)) ? '0 : p + 1'b1;
  endfunction
endpackage

// ----- rtl/brfs_ram.sv -----
// generic single write port, single read port ram with registered read
// no dependencies
module brfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/brfs_front.sv -----
// front end: takes commands, classifies them and queues them for the back end
// depends on brfs_pkg
module brfs_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [brfs_pkg::OP_W-1:0]   op,
  input  logic [brfs_pkg::BYTE_W-1:0] data_in,
  input  logic [brfs_pkg::BYTE_W-1:0] search_value,
  output brfs_pkg::cmd_q_t            q_head,
  input  logic                        q_pop
);
  import brfs_pkg::*;

  cmd_t       q_r [2];
  logic       rd_idx_r, rd_idx_nxt;
  logic       wr_idx_r, wr_idx_nxt;
  logic [1:0] q_cnt_r, q_cnt_nxt;
  logic       push;
  cmd_t       cls;

  assign busy = (q_cnt_r == 2'd2);
  assign push = start && !busy;

  // unused codes collapse to a no-op; the argument is the byte the op needs
  always_comb begin
    cls.op  = op;
    cls.arg = data_in;
    case (op)
      OP_PUSH, OP_POP, OP_FLUSH, OP_COPY: cls.arg = data_in;
      OP_FIND: cls.arg = search_value;
      default: cls.op = OP_NOP;
    endcase
  end

  always_comb begin
    rd_idx_nxt = rd_idx_r;
    wr_idx_nxt = wr_idx_r;
    q_cnt_nxt  = q_cnt_r;
    if (push) begin
      wr_idx_nxt = ~wr_idx_r;
    end
    if (q_pop) begin
      rd_idx_nxt = ~rd_idx_r;
    end
    if (push && !q_pop) begin
      q_cnt_nxt = q_cnt_r + 2'd1;
    end else if (!push && q_pop) begin
      q_cnt_nxt = q_cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r <= 1'b0;
      wr_idx_r <= 1'b0;
      q_cnt_r  <= 2'd0;
    end else begin
      rd_idx_r <= rd_idx_nxt;
      wr_idx_r <= wr_idx_nxt;
      q_cnt_r  <= q_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_idx_r] <= cls;
    end
  end

  assign q_head.valid = (q_cnt_r != 2'd0);
  assign q_head.cmd   = q_r[rd_idx_r];
endmodule

// ----- rtl/brfs_back.sv -----
// back end: owns the ring pointers and the slot ram, carries out commands
// depends on brfs_pkg and brfs_ram
module brfs_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  brfs_pkg::cmd_q_t            q_head,
  output logic                        q_pop,
  output logic                        out_valid,
  output logic [brfs_pkg::BYTE_W-1:0] out_data_out,
  output logic                        out_ok,
  output logic [brfs_pkg::CNT_W-1:0]  out_position,
  output logic [brfs_pkg::CNT_W-1:0]  out_fill_count,
  output logic                        out_is_empty,
  output logic                        out_is_full,
  output logic                        out_last
);
  import brfs_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_POPW = 2'd1;
  localparam logic [1:0] ST_WALK = 2'd2;

  logic [1:0]        state_r, state_nxt;
  ptr_t              rp_r, rp_nxt;
  ptr_t              wp_r, wp_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [OP_W-1:0]   op_r, op_nxt;
  logic [BYTE_W-1:0] key_r, key_nxt;
  ptr_t              iss_ptr_r, iss_ptr_nxt;
  logic [CNT_W-1:0]  iss_cnt_r, iss_cnt_nxt;
  logic [CNT_W-1:0]  didx_r, didx_nxt;

  logic              valid_r, valid_nxt;
  logic [BYTE_W-1:0] data_r, data_nxt;
  logic              ok_r, ok_nxt;
  logic [CNT_W-1:0]  pos_r, pos_nxt;
  logic              last_r, last_nxt;
  logic [CNT_W-1:0]  fill_r;
  logic              empty_r, full_r;

  logic              we;
  ptr_t              raddr;
  logic [BYTE_W-1:0] rdata;
  logic              final_idx;

  brfs_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(SLOT_COUNT)
  ) u_slots (
    .clk  (clk),
    .we   (we),
    .waddr(wp_r),
    .wdata(q_head.cmd.arg),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign final_idx = (didx_r == cnt_r - 1'b1);

  always_comb begin
    state_nxt   = state_r;
    rp_nxt      = rp_r;
    wp_nxt      = wp_r;
    cnt_nxt     = cnt_r;
    op_nxt      = op_r;
    key_nxt     = key_r;
    iss_ptr_nxt = iss_ptr_r;
    iss_cnt_nxt = iss_cnt_r;
    didx_nxt    = didx_r;
    q_pop       = 1'b0;
    we          = 1'b0;
    raddr       = rp_r;
    valid_nxt   = 1'b0;
    data_nxt    = '0;
    ok_nxt      = 1'b0;
    pos_nxt     = '0;
    last_nxt    = 1'b1;
    case (state_r)
      ST_IDLE: begin
        if (q_head.valid) begin
          q_pop  = 1'b1;
          op_nxt = q_head.cmd.op;
          key_nxt = q_head.cmd.arg;
          case (q_head.cmd.op)
            OP_PUSH: begin
              valid_nxt = 1'b1;
              if (cnt_r != CNT_W'(CAPACITY)) begin
                we      = 1'b1;
                wp_nxt  = ptr_inc(wp_r);
                cnt_nxt = cnt_r + 1'b1;
                ok_nxt  = 1'b1;
              end
            end
            OP_POP: begin
              if (cnt_r == '0) begin
                valid_nxt = 1'b1;
              end else begin
                state_nxt = ST_POPW;
              end
            end
            OP_FLUSH: begin
              rp_nxt    = wp_r;
              cnt_nxt   = '0;
              valid_nxt = 1'b1;
            end
            OP_FIND, OP_COPY: begin
              if (cnt_r == '0) begin
                valid_nxt = 1'b1;
              end else begin
                // slot of the oldest byte is read now, data back next cycle
                iss_ptr_nxt = ptr_inc(rp_r);
                iss_cnt_nxt = CNT_W'(1);
                didx_nxt    = '0;
                state_nxt   = ST_WALK;
              end
            end
            default: begin
              valid_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_POPW: begin
        valid_nxt = 1'b1;
        data_nxt  = rdata;
        ok_nxt    = 1'b1;
        rp_nxt    = ptr_inc(rp_r);
        cnt_nxt   = cnt_r - 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_WALK: begin
        // one read in flight per cycle, compare the one that has landed
        raddr = iss_ptr_r;
        if (iss_cnt_r != cnt_r) begin
          iss_ptr_nxt = ptr_inc(iss_ptr_r);
          iss_cnt_nxt = iss_cnt_r + 1'b1;
        end
        didx_nxt = didx_r + 1'b1;
        if (op_r == OP_FIND) begin
          if (rdata == key_r) begin
            valid_nxt = 1'b1;
            pos_nxt   = didx_r + 1'b1;
            state_nxt = ST_IDLE;
          end else if (final_idx) begin
            valid_nxt = 1'b1;
            state_nxt = ST_IDLE;
          end
        end else begin
          valid_nxt = 1'b1;
          data_nxt  = rdata;
          ok_nxt    = 1'b1;
          last_nxt  = final_idx;
          if (final_idx) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rp_r    <= '0;
      wp_r    <= '0;
      cnt_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rp_r    <= rp_nxt;
      wp_r    <= wp_nxt;
      cnt_r   <= cnt_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    key_r     <= key_nxt;
    iss_ptr_r <= iss_ptr_nxt;
    iss_cnt_r <= iss_cnt_nxt;
    didx_r    <= didx_nxt;
    data_r    <= data_nxt;
    ok_r      <= ok_nxt;
    pos_r     <= pos_nxt;
    last_r    <= last_nxt;
    fill_r    <= cnt_nxt;
    empty_r   <= (cnt_nxt == '0);
    full_r    <= (cnt_nxt == CNT_W'(CAPACITY));
  end

  assign out_valid      = valid_r;
  assign out_data_out   = data_r;
  assign out_ok         = ok_r;
  assign out_position   = pos_r;
  assign out_fill_count = fill_r;
  assign out_is_empty   = empty_r;
  assign out_is_full    = full_r;
  assign out_last       = last_r;
endmodule

// ----- rtl/byte_ring_fifo_with_search.sv -----
// top level of the byte ring fifo with search: front end, command queue, back end
// depends on brfs_pkg, brfs_front, brfs_back and the assertion macro header
//
//  channel   handshake          payload
//  input     start / busy       in_operation, in_data_in, in_search_value
//  result    out_valid strobe   out_data_out, out_ok, out_position, out_fill_count,
//                               out_is_empty, out_is_full, out_last
//
// push, flush and no-op results pass through the command queue and the result registers; pop
// also waits for the registered ram read; find and copy: setup, then one ram read per stored byte;
// copy gives one result a cycle, find stops at the first match
// the back end runs one command at a time, set by the single slot ram read port
// a two-entry command queue lets the front take transfers while the back is busy;
// busy rises only when that queue is full
// rst_n clears the pointers, fill count and queue; the slot ram is not cleared
`include "byte_ring_fifo_with_search_defines.svh"
module byte_ring_fifo_with_search (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [brfs_pkg::OP_W-1:0]   in_operation,
  input  logic [brfs_pkg::BYTE_W-1:0] in_data_in,
  input  logic [brfs_pkg::BYTE_W-1:0] in_search_value,
  output logic                        out_valid,
  output logic [brfs_pkg::BYTE_W-1:0] out_data_out,
  output logic                        out_ok,
  output logic [brfs_pkg::CNT_W-1:0]  out_position,
  output logic [brfs_pkg::CNT_W-1:0]  out_fill_count,
  output logic                        out_is_empty,
  output logic                        out_is_full,
  output logic                        out_last
);
  import brfs_pkg::*;

  cmd_q_t q_head;
  logic   q_pop;

  brfs_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .op          (in_operation),
    .data_in     (in_data_in),
    .search_value(in_search_value),
    .q_head      (q_head),
    .q_pop       (q_pop)
  );

  brfs_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_data_out  (out_data_out),
    .out_ok        (out_ok),
    .out_position  (out_position),
    .out_fill_count(out_fill_count),
    .out_is_empty  (out_is_empty),
    .out_is_full   (out_is_full),
    .out_last      (out_last)
  );

  // copy transfers run back to back until the final byte
  `BRFS_ASSERT_NXT(a_copy_burst, clk, rst_n, out_valid && !out_last, out_valid && out_ok, "copy burst broken")
  // a find hit never reports ok
  `BRFS_ASSERT_IMP(a_find_no_ok, clk, rst_n, out_valid && out_position != '0, !out_ok && out_data_out == '0, "find result carries data")
  // status flags agree with the fill count
  `BRFS_ASSERT_IMP(a_status, clk, rst_n, out_valid, (out_is_empty == (out_fill_count == '0)) && (out_is_full == (out_fill_count == CNT_W'(CAPACITY))), "status flags disagree with fill count")
  // a queue pop only happens when the queue holds a command
  `BRFS_ASSERT_IMP(a_pop_valid, clk, rst_n, q_pop, q_head.valid, "command queue underflow")
endmodule
